// ===== sv/spd_pkg.sv =====
// Shared types and constants of the segment pack descriptor generator.
`timescale 1ns / 1ps
package spd_pkg;

    localparam int ADDR_W    = 48;
    localparam int DISP_W    = 48;
    localparam int LEN_W     = 31;
    localparam int OFF_W     = 38;
    localparam int REC_W     = 24;
    localparam int EXT_W     = 47;
    localparam int CNT_CFG_W = 7;
    localparam int ENTRY_W   = 6;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W     = 24;
    localparam int Q_DEPTH   = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PACK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNPACK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_EXTENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [ENTRY_W-1:0]        entry_index;
        logic signed [DISP_W-1:0]  entry_displacement;
        logic [LEN_W-1:0]          entry_length;
        logic [REC_W-1:0]          record_index;
        logic [ADDR_W-1:0]         user_base;
        logic [ADDR_W-1:0]         pack_base;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] source_address;
        logic [ADDR_W-1:0] dest_address;
        logic [LEN_W-1:0]  byte_count;
        logic              last_descriptor;
    } t_out_item;

    // One segment table word.
    typedef struct packed {
        logic [DISP_W-1:0] disp;
        logic [LEN_W-1:0]  len;
        logic [OFF_W-1:0]  off;
    } t_seg;

    typedef enum logic [1:0] {
        K_LOAD,
        K_PACK,
        K_UNPACK
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_in_item item;
    } t_qentry;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_EMIT
    } t_back_state;

endpackage

// ===== sv/segment_pack_descriptor_generator.sv =====
// Top level of the segment pack descriptor generator.
// Flow: a load is written to the table as it leaves the queue. A pack or unpack makes four
//   passes through one 24x24 multiplier (MS_EXT_LO to MS_SIZE_HI, folded up to MS_DONE),
//   then reads the table once per segment; each read passes the read and output registers,
//   and the record's descriptors then follow one per cycle.
// The 2-entry queue accepts new items while the back part works; busy means it is full.
// Reset (synchronous, active low) empties the queue, idles the back part, clears the config
//   registers and the packed total; the segment table is not cleared. Results cannot stall.
`timescale 1ns / 1ps
module segment_pack_descriptor_generator import spd_pkg::*; #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_in_item             i_item,
    output logic                 busy,
    output logic                 o_valid,
    output t_out_item            o_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [EXT_W-1:0]     i_cfg_data
);

    // Configuration registers; write them only while the block is idle (the block does not enforce it).
    logic [EXT_W-1:0]     r_record_extent;
    logic [CNT_CFG_W-1:0] r_segment_count;

    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_qentry w_entry;
    t_qentry w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_extent <= '0;
            r_segment_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RECORD_EXTENT: r_record_extent <= i_cfg_data;
                CFG_SEGMENT_COUNT: r_segment_count <= i_cfg_data[CNT_CFG_W-1:0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // Front: take the item, decode it, drop unused codes and out-of-range loads.
    spd_front #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_front (
        .i_start(start),
        .i_item (i_item),
        .i_full (w_full),
        .o_busy (busy),
        .o_push (w_push),
        .o_entry(w_entry)
    );

    // Hold decoded items in order so loads never overtake records.
    spd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_entry(w_entry),
        .i_pop  (w_pop),
        .o_head (w_head),
        .o_full (w_full),
        .o_empty(w_empty)
    );

    // Back: write the table on loads, walk the table on records.
    spd_back #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_record_extent(r_record_extent),
        .i_segment_count(r_segment_count),
        .o_valid        (o_valid),
        .o_item         (o_item)
    );

endmodule

// ===== sv/spd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/spd_queue.sv =====
// Short in-order queue between the front and back parts.
`timescale 1ns / 1ps
module spd_queue import spd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qentry i_entry,
    input  logic    i_pop,
    output t_qentry o_head,
    output logic    o_full,
    output logic    o_empty
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_qentry         r_q [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;

    assign o_head  = r_q[r_rd_ptr];
    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== sv/spd_front.sv =====
// Front part: accept items, classify them and drop the ones that do nothing.
`timescale 1ns / 1ps
module spd_front import spd_pkg::*; #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic     i_start,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_busy,
    output logic     o_push,
    output t_qentry  o_entry
);

    logic w_accept;
    logic w_keep;
    t_kind w_kind;

    assign o_busy   = i_full;
    assign w_accept = i_start && !i_full;

    always_comb begin
        w_kind = K_LOAD;
        w_keep = 1'b0;
        case (i_item.command)
            CMD_LOAD: begin
                w_kind = K_LOAD;
                w_keep = (int'(i_item.entry_index) < MAX_SEGMENTS);
            end
            CMD_PACK: begin
                w_kind = K_PACK;
                w_keep = 1'b1;
            end
            CMD_UNPACK: begin
                w_kind = K_UNPACK;
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_push       = w_accept && w_keep;
    assign o_entry.kind = w_kind;
    assign o_entry.item = i_item;

endmodule

// ===== sv/spd_back.sv =====
// Back part: apply loads to the segment table and expand records into descriptors.
`timescale 1ns / 1ps
module spd_back import spd_pkg::*; #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  t_qentry              i_head,
    output logic                 o_pop,
    input  logic [EXT_W-1:0]     i_record_extent,
    input  logic [CNT_CFG_W-1:0] i_segment_count,
    output logic                 o_valid,
    output t_out_item            o_item
);

    localparam int AW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int SAT_W  = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;
    localparam int STEP_W = 3;
    localparam int SEG_W  = $bits(t_seg);

    // Multiply sequence steps: one partial product per step up to MS_SIZE_HI; MS_DONE only folds.
    localparam logic [STEP_W-1:0] MS_EXT_LO  = 3'd0;
    localparam logic [STEP_W-1:0] MS_EXT_HI  = 3'd1;
    localparam logic [STEP_W-1:0] MS_SIZE_LO = 3'd2;
    localparam logic [STEP_W-1:0] MS_SIZE_HI = 3'd3;
    localparam logic [STEP_W-1:0] MS_DONE    = 3'd4;

    t_back_state         r_state;
    t_back_state         n_state;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic [AW-1:0]       r_rd_idx;
    logic [AW-1:0]       n_rd_idx;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    n_n;
    logic [OFF_W-1:0]    r_total;
    logic [OFF_W-1:0]    n_total;
    logic                r_rd_valid;
    logic                r_rd_last;
    logic                r_out_valid;

    logic [REC_W-1:0]    r_rec;
    logic [ADDR_W-1:0]   r_user_base;
    logic [ADDR_W-1:0]   r_pack_base;
    logic                r_unpack;
    logic [ADDR_W-1:0]   r_prod;
    logic [ADDR_W-1:0]   r_user_rec;
    logic [ADDR_W-1:0]   r_pack_rec;
    t_out_item           r_out;

    logic                w_we;
    logic                w_ld;
    logic                w_re;
    logic                w_rd_last;
    logic [CNT_W-1:0]    w_sat;
    t_seg                w_seg_wr;
    t_seg                w_seg_rd;
    logic [SEG_W-1:0]    w_rdata;
    logic [MUL_W-1:0]    w_op;
    logic [ADDR_W-1:0]   w_prod;
    logic [ADDR_W-1:0]   w_ua;
    logic [ADDR_W-1:0]   w_pa;

    // Saturate the configured count to the table depth.
    assign w_sat = (SAT_W'(i_segment_count) > SAT_W'(MAX_SEGMENTS))
                 ? CNT_W'(MAX_SEGMENTS) : CNT_W'(i_segment_count);

    // Entry 0 restarts the running packed total.
    assign w_seg_wr.disp = i_head.item.entry_displacement;
    assign w_seg_wr.len  = i_head.item.entry_length;
    assign w_seg_wr.off  = (i_head.item.entry_index == '0) ? '0 : r_total;

    spd_ram #(
        .WIDTH(SEG_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(AW'(i_head.item.entry_index)),
        .i_wdata(w_seg_wr),
        .i_re   (w_re),
        .i_raddr(r_rd_idx),
        .o_rdata(w_rdata)
    );

    assign w_seg_rd = t_seg'(w_rdata);

    always_comb begin
        case (r_step)
            MS_EXT_LO:  w_op = i_record_extent[MUL_W-1:0];
            MS_EXT_HI:  w_op = MUL_W'(i_record_extent[EXT_W-1:MUL_W]);
            MS_SIZE_LO: w_op = r_total[MUL_W-1:0];
            MS_SIZE_HI: w_op = MUL_W'(r_total[OFF_W-1:MUL_W]);
            default:    w_op = '0;
        endcase
    end

    assign w_prod = ADDR_W'(r_rec) * ADDR_W'(w_op);

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_rd_idx  = r_rd_idx;
        n_n       = r_n;
        n_total   = r_total;
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_ld      = 1'b0;
        w_re      = 1'b0;
        w_rd_last = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_head.kind == K_LOAD) begin
                        w_we    = 1'b1;
                        n_total = w_seg_wr.off + OFF_W'(i_head.item.entry_length);
                    end else begin
                        w_ld = 1'b1;
                        n_n  = w_sat;
                        if (w_sat != '0) begin
                            n_state = BK_MUL;
                            n_step  = MS_EXT_LO;
                        end
                    end
                end
            end
            BK_MUL: begin
                if (r_step == MS_DONE) begin
                    n_state  = BK_EMIT;
                    n_rd_idx = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            BK_EMIT: begin
                w_re      = 1'b1;
                w_rd_last = (CNT_W'(r_rd_idx) == r_n - CNT_W'(1));
                if (w_rd_last) begin
                    n_state = BK_IDLE;
                end else begin
                    n_rd_idx = r_rd_idx + AW'(1);
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= MS_EXT_LO;
            r_rd_idx    <= '0;
            r_n         <= '0;
            r_total     <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_rd_idx    <= n_rd_idx;
            r_n         <= n_n;
            r_total     <= n_total;
            r_rd_valid  <= w_re;
            r_rd_last   <= w_rd_last;
            r_out_valid <= r_rd_valid;
        end
    end

    // Addresses of one descriptor.
    assign w_ua = r_user_rec + w_seg_rd.disp;
    assign w_pa = r_pack_rec + ADDR_W'(w_seg_rd.off);

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_rec       <= i_head.item.record_index;
            r_user_base <= i_head.item.user_base;
            r_pack_base <= i_head.item.pack_base;
            r_unpack    <= (i_head.kind == K_UNPACK);
        end
        r_prod <= w_prod;
        if (r_state == BK_MUL) begin
            // Fold in the product registered in the previous step.
            case (r_step)
                MS_EXT_HI:  r_user_rec <= r_user_base + r_prod;
                MS_SIZE_LO: r_user_rec <= r_user_rec
                                        + {r_prod[ADDR_W-MUL_W-1:0], {MUL_W{1'b0}}};
                MS_SIZE_HI: r_pack_rec <= r_pack_base + r_prod;
                MS_DONE:    r_pack_rec <= r_pack_rec
                                        + {r_prod[ADDR_W-MUL_W-1:0], {MUL_W{1'b0}}};
                default: begin
                end
            endcase
        end
        if (r_rd_valid) begin
            r_out.source_address  <= r_unpack ? w_pa : w_ua;
            r_out.dest_address    <= r_unpack ? w_ua : w_pa;
            r_out.byte_count      <= w_seg_rd.len;
            r_out.last_descriptor <= r_rd_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ===== sv/spd_chk.sv =====
// Port-level checks of the segment pack descriptor generator, bound to the top level.
`timescale 1ns / 1ps
module spd_chk import spd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_valid,
    input t_out_item o_item
);

    // Reset leaves no descriptor pending and the queue open.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("descriptor or busy right after reset");

    // The queue only fills after an item was offered.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an offered item");

    // Descriptors of one record come out without gaps.
    a_record_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.last_descriptor |=> o_valid)
        else $error("gap inside a record's descriptors");

    // A new record needs its address setup before its first descriptor.
    a_record_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.last_descriptor |=> !o_valid)
        else $error("descriptor right after the last one of a record");

endmodule

bind segment_pack_descriptor_generator spd_chk u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid),
    .o_item (o_item)
);
